[sv/fwcc_pkg.sv]
// fwcc_pkg: shared constants, codes and the table entry type of the file window cache.
// No dependencies. Used by fwcc_table, file_window_cache_clock and the testbench.

package fwcc_pkg;

    // table geometry
    localparam int NUM_WINDOWS = 8;
    localparam int IDX_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int CNT_W       = $clog2(NUM_WINDOWS + 1);

    // field widths
    localparam int OFF_W      = 48;
    localparam int LEN_W      = 17;
    localparam int DELTA_W    = 32;
    localparam int BIE_W      = 16;
    localparam int EIDX_W     = 3;
    localparam int TYPE_W     = 3;
    localparam int CHUNKS_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 136;

    // window alignment
    localparam int ALIGN_BYTES = 512;
    localparam logic [OFF_W-1:0] ALIGN_MASK = ~(OFF_W'(ALIGN_BYTES - 1));

    // request types
    localparam logic [TYPE_W-1:0] REQ_GET       = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_GET_UNCHK = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_SEQ       = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_SET       = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_MOVE      = 3'd4;

    // result status codes
    localparam logic [2:0] STAT_HIT    = 3'd0;
    localparam logic [2:0] STAT_MISS   = 3'd1;
    localparam logic [2:0] STAT_BEYOND = 3'd2;
    localparam logic [2:0] STAT_ACCEPT = 3'd3;
    localparam logic [2:0] STAT_REJECT = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILE_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS    = 2'd2;

    localparam logic [LEN_W-1:0]    CHUNK_RESET  = 17'd4096;
    localparam logic [CHUNKS_W-1:0] CHUNKS_RESET = 4'd8;

    // one cached window
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] limit;
    } entry_t;

endpackage

[sv/fwcc_table.sv]
// fwcc_table: window table memory (start/limit per entry) with a registered read port.
// Per-entry valid bits make never-written or cleared entries read as zero. Uses fwcc_pkg.

module fwcc_table import fwcc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             clear,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t                 tbl_mem [NUM_WINDOWS];
    entry_t                 rd_q_reg;
    logic                   rd_valid_reg;
    logic [NUM_WINDOWS-1:0] valid_reg;

    // memory array: write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_q_reg <= tbl_mem[rd_addr];
        end
    end

    // valid bits, cleared at reset and on a file size write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                valid_reg <= '0;
            end else if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // an entry that was never filled reads as an empty window
    assign rd_data = rd_valid_reg ? rd_q_reg : '0;

endmodule

[sv/file_window_cache_clock.sv]
// file_window_cache_clock: top level of the file window cache with second-chance replacement.
// Depends on fwcc_pkg and fwcc_table.
//
// Usage:
//   Requests enter on the s_ stream (s_tuser = request type, s_tdata = offset, length, delta).
//   Each request yields exactly one result transaction on the m_ stream (m_tuser = status).
//   Configuration is written through cfg_wr_en/cfg_index/cfg_wdata while no request is open;
//   a file size write empties the table and sets the read position to zero.
// Request flow:
//   The window table sits in a memory read one entry per cycle, and the hit search compares
//   each returned entry in turn; a miss runs the whole search, the second-chance sweep (one
//   used bit per cycle), the fill calculation in S_CALC and S_CHECK, and the output state.
//   Position requests pass S_POS1, S_POS2 and the output state. One request is processed at a time;
//   s_tready is high whenever the engine is free, even while a result waits on m_.
// Reset: synchronous, active low; table empty, position 0, file size 0, chunk 4096, 8 entries.
// Stall: a result is held in the output register until m_tready; a finished request waits
//   in the output state for the register to free, so no result is lost or overwritten.

module file_window_cache_clock import fwcc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // offset[47:0], access_length[64:48],
                                             // move_delta[96:65], zero pad[103:97]
    input  logic [TYPE_W-1:0]     s_tuser,   // req_type[2:0]
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // entry_index[2:0], byte_in_entry[18:3],
                                             // fill_start[66:19], fill_length[83:67],
                                             // read_position[131:84], zero pad[135:132]
    output logic [2:0]            m_tuser,   // status[2:0]
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SWEEP  = 3'd2;
    localparam logic [2:0] S_CALC   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_POS1   = 3'd5;
    localparam logic [2:0] S_POS2   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // configuration registers
    logic [OFF_W-1:0]    fs_reg;
    logic [LEN_W-1:0]    chunk_reg;
    logic [CHUNKS_W-1:0] chunks_reg;
    logic [CNT_W-1:0]    n_act;

    // control state
    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       rd_idx_reg, rd_idx_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pidx_reg, pidx_next;
    logic [IDX_W-1:0]       v_reg, v_next;
    logic [NUM_WINDOWS-1:0] used_reg, used_next;
    logic [OFF_W-1:0]       seq_reg, seq_next;
    logic                   m_valid_reg, m_valid_next;

    // request and working payload
    logic [TYPE_W-1:0]  typ_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic [OFF_W-1:0]   lim_reg, lim_next;
    logic [OFF_W+1:0]   np_reg, np_next;

    // result staging
    logic [2:0]       res_stat_reg, res_stat_next;
    logic [IDX_W-1:0] res_idx_reg, res_idx_next;
    logic [BIE_W-1:0] res_bie_reg, res_bie_next;
    logic [OFF_W-1:0] res_fs_reg, res_fs_next;
    logic [LEN_W-1:0] res_fl_reg, res_fl_next;

    // output register
    logic [2:0]        out_stat_reg;
    logic [EIDX_W-1:0] out_idx_reg;
    logic [BIE_W-1:0]  out_bie_reg;
    logic [OFF_W-1:0]  out_fs_reg;
    logic [LEN_W-1:0]  out_fl_reg;
    logic [OFF_W-1:0]  out_rp_reg;
    logic              load_out;

    // table port
    logic   tbl_clear;
    logic   rd_en;
    logic   wr_en;
    entry_t rd_data;
    entry_t wr_data;

    // datapath terms
    logic             accept;
    logic             is_seq;
    logic             checked;
    logic             last_pend;
    logic [OFF_W:0]   hit_room;
    logic             hit;
    logic [OFF_W-1:0] hit_bie;
    logic [OFF_W-1:0] st;
    logic [OFF_W:0]   fs_room;
    logic [OFF_W:0]   lim_room;
    logic             beyond;
    logic [OFF_W-1:0] miss_bie;
    logic [OFF_W-1:0] fill_len;
    logic [OFF_W-1:0] seq_adv;
    logic             pos_ok;

    fwcc_table u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (tbl_clear),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[IDX_W-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (v_reg),
        .wr_data (wr_data)
    );

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign tbl_clear = cfg_wr_en && (cfg_index == CFG_FILE_SIZE);

    // active entry count, clamped to 1..NUM_WINDOWS
    always_comb begin
        if (chunks_reg == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(chunks_reg) > NUM_WINDOWS) begin
            n_act = CNT_W'(NUM_WINDOWS);
        end else begin
            n_act = CNT_W'(chunks_reg);
        end
    end

    assign is_seq    = (typ_reg == REQ_SEQ);
    assign checked   = (typ_reg != REQ_GET_UNCHK);
    assign last_pend = (CNT_W'(pidx_reg) == n_act - CNT_W'(1));
    assign seq_adv   = seq_reg + OFF_W'(len_reg);

    // hit test on the entry returned by the memory
    assign hit_room = {1'b0, rd_data.limit} - {1'b0, off_reg};
    assign hit      = (off_reg >= rd_data.start) && !hit_room[OFF_W]
                      && (hit_room[OFF_W-1:0] > OFF_W'(len_reg));
    assign hit_bie  = off_reg - rd_data.start;

    // new window bounds
    assign st       = off_reg & ALIGN_MASK;
    assign fs_room  = {1'b0, fs_reg} - {1'b0, st};
    assign lim_room = {1'b0, lim_reg} - {1'b0, off_reg};
    assign beyond   = lim_room[OFF_W] || (lim_room[OFF_W-1:0] < OFF_W'(len_reg));
    assign miss_bie = off_reg - st;
    assign fill_len = (lim_reg > st) ? (lim_reg - st) : '0;
    assign wr_data  = '{start: st, limit: lim_reg};

    // position check: no underflow and within the file
    assign pos_ok = !np_reg[OFF_W+1] && (np_reg[OFF_W:0] <= {1'b0, fs_reg});

    // request sequencer
    always_comb begin
        state_next    = state_reg;
        rd_idx_next   = rd_idx_reg;
        pend_next     = pend_reg;
        pidx_next     = pidx_reg;
        v_next        = v_reg;
        used_next     = used_reg;
        seq_next      = seq_reg;
        lim_next      = lim_reg;
        np_next       = np_reg;
        res_stat_next = res_stat_reg;
        res_idx_next  = res_idx_reg;
        res_bie_next  = res_bie_reg;
        res_fs_next   = res_fs_reg;
        res_fl_next   = res_fl_reg;
        m_valid_next  = m_valid_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        load_out      = 1'b0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    rd_idx_next  = '0;
                    pend_next    = 1'b0;
                    v_next       = '0;
                    res_idx_next = '0;
                    res_bie_next = '0;
                    res_fs_next  = '0;
                    res_fl_next  = '0;
                    if (s_tuser inside {REQ_GET, REQ_GET_UNCHK, REQ_SEQ}) begin
                        state_next = S_SEARCH;
                    end else if (s_tuser inside {REQ_SET, REQ_MOVE}) begin
                        state_next = S_POS1;
                    end else begin
                        res_stat_next = STAT_REJECT;
                        state_next    = S_OUT;
                    end
                end
            end
            // one memory read per cycle, compare on the returned entry
            S_SEARCH: begin
                if (pend_reg && hit) begin
                    used_next[pidx_reg] = 1'b1;
                    if (is_seq) begin
                        seq_next = seq_adv;
                    end
                    res_stat_next = STAT_HIT;
                    res_idx_next  = pidx_reg;
                    res_bie_next  = hit_bie[BIE_W-1:0];
                    state_next    = S_OUT;
                end else if (pend_reg && last_pend) begin
                    state_next = S_SWEEP;
                end else if (rd_idx_reg < n_act) begin
                    rd_en       = 1'b1;
                    pend_next   = 1'b1;
                    pidx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            // second chance: clear used bits until a clear one is found
            S_SWEEP: begin
                if (!used_reg[v_reg]) begin
                    state_next = S_CALC;
                end else begin
                    used_next[v_reg] = 1'b0;
                    if (CNT_W'(v_reg) == n_act - CNT_W'(1)) begin
                        v_next = '0;
                    end else begin
                        v_next = v_reg + IDX_W'(1);
                    end
                end
            end
            S_CALC: begin
                if (fs_room[OFF_W] || (fs_room[OFF_W-1:0] < OFF_W'(chunk_reg))) begin
                    lim_next = fs_reg;
                end else begin
                    lim_next = st + OFF_W'(chunk_reg);
                end
                state_next = S_CHECK;
            end
            S_CHECK: begin
                res_idx_next = v_reg;
                if (checked && beyond) begin
                    res_stat_next = STAT_BEYOND;
                end else begin
                    wr_en            = 1'b1;
                    used_next[v_reg] = 1'b1;
                    if (is_seq) begin
                        seq_next = seq_adv;
                    end
                    res_stat_next = STAT_MISS;
                    res_bie_next  = miss_bie[BIE_W-1:0];
                    res_fs_next   = st;
                    res_fl_next   = fill_len[LEN_W-1:0];
                end
                state_next = S_OUT;
            end
            S_POS1: begin
                if (typ_reg == REQ_SET) begin
                    np_next = {2'b00, off_reg};
                end else begin
                    np_next = {2'b00, seq_reg}
                              + {{(OFF_W + 2 - DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};
                end
                state_next = S_POS2;
            end
            S_POS2: begin
                if (pos_ok) begin
                    seq_next      = np_reg[OFF_W-1:0];
                    res_stat_next = STAT_ACCEPT;
                end else begin
                    res_stat_next = STAT_REJECT;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    load_out     = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // file size write empties the table and rewinds
        if (tbl_clear) begin
            used_next = '0;
            seq_next  = '0;
        end
    end

    // control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            rd_idx_reg  <= '0;
            pend_reg    <= 1'b0;
            pidx_reg    <= '0;
            v_reg       <= '0;
            used_reg    <= '0;
            seq_reg     <= '0;
            m_valid_reg <= 1'b0;
            fs_reg      <= '0;
            chunk_reg   <= CHUNK_RESET;
            chunks_reg  <= CHUNKS_RESET;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            pend_reg    <= pend_next;
            pidx_reg    <= pidx_next;
            v_reg       <= v_next;
            used_reg    <= used_next;
            seq_reg     <= seq_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_FILE_SIZE: fs_reg     <= cfg_wdata[OFF_W-1:0];
                    CFG_CHUNK:     chunk_reg  <= cfg_wdata[LEN_W-1:0];
                    CFG_CHUNKS:    chunks_reg <= cfg_wdata[CHUNKS_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            typ_reg   <= s_tuser;
            off_reg   <= (s_tuser == REQ_SEQ) ? seq_reg : s_tdata[OFF_W-1:0];
            len_reg   <= s_tdata[OFF_W +: LEN_W];
            delta_reg <= s_tdata[OFF_W + LEN_W +: DELTA_W];
        end
        lim_reg      <= lim_next;
        np_reg       <= np_next;
        res_stat_reg <= res_stat_next;
        res_idx_reg  <= res_idx_next;
        res_bie_reg  <= res_bie_next;
        res_fs_reg   <= res_fs_next;
        res_fl_reg   <= res_fl_next;
        if (load_out) begin
            out_stat_reg <= res_stat_reg;
            out_idx_reg  <= EIDX_W'(res_idx_reg);
            out_bie_reg  <= res_bie_reg;
            out_fs_reg   <= res_fs_reg;
            out_fl_reg   <= res_fl_reg;
            out_rp_reg   <= seq_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_stat_reg;
    assign m_tdata  = {4'b0000, out_rp_reg, out_fl_reg, out_fs_reg, out_bie_reg, out_idx_reg};

    // the sweep pointer stays inside the active entries
    a_sweep_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SWEEP |-> CNT_W'(v_reg) < n_act)
        else $error("sweep pointer outside active entries");

    // a pending memory read always belongs to an active entry
    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg && state_reg == S_SEARCH |-> CNT_W'(pidx_reg) < n_act)
        else $error("search read outside active entries");

    // an accepted position lies within the file
    a_pos_in_file: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_stat_reg == STAT_ACCEPT |-> out_rp_reg <= fs_reg)
        else $error("accepted position beyond file end");

    // a fill never loads more than one chunk
    a_fill_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_stat_reg == STAT_MISS |-> out_fl_reg <= chunk_reg)
        else $error("fill length exceeds chunk size");

    // the table is never read and written in the same cycle
    a_rw_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en && !tbl_clear)
        else $error("table read collides with write or clear");

endmodule

[tb/file_window_cache_clock_test.sv]
// Self-checking testbench of file_window_cache_clock: directed and random request traffic,
// checked against an internal model of the window table and read position.
// Depends on fwcc_pkg and the file_window_cache_clock RTL.
`timescale 1ns / 1ps

module file_window_cache_clock_test;
    import fwcc_pkg::*;

    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 60;
    localparam logic [63:0] OFF_MASK = 64'hFFFF_FFFF_FFFF;

    // one expected or observed result transaction
    typedef struct packed {
        logic [2:0]        status;
        logic [EIDX_W-1:0] entry;
        logic [BIE_W-1:0]  bie;
        logic [OFF_W-1:0]  fill_start;
        logic [LEN_W-1:0]  fill_len;
        logic [OFF_W-1:0]  rd_pos;
    } cache_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [TYPE_W-1:0]     s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model of the cache state and registers
    logic [63:0] win_start [NUM_WINDOWS];
    logic [63:0] win_limit [NUM_WINDOWS];
    logic        win_used  [NUM_WINDOWS];
    logic [47:0] rd_pos;
    logic [63:0] cfg_file_size;
    logic [63:0] cfg_chunk;
    logic [3:0]  cfg_active;

    cache_result_t pending_results[$];
    cache_result_t got_result;
    cache_result_t want_result;
    int            err_count      = 0;
    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            idle_cycles    = 0;

    file_window_cache_clock uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // empty table, position zero
    function automatic void clear_windows();
        for (int i = 0; i < NUM_WINDOWS; i++) begin
            win_start[i] = '0;
            win_limit[i] = '0;
            win_used[i]  = 1'b0;
        end
        rd_pos = '0;
    endfunction

    // expected result of one request; updates the model state
    function automatic cache_result_t predict_access(input logic [2:0] kind,
                                                     input logic [47:0] off_in,
                                                     input logic [16:0] len_in,
                                                     input logic [31:0] delta);
        cache_result_t r;
        logic [63:0]   off, len, st, lim, mag, np, pos;
        int            n, v, i;
        bit            found, ok;
        r     = '0;
        len   = 64'(len_in);
        pos   = 64'(rd_pos);
        found = 1'b0;
        v     = 0;
        case (kind)
            REQ_GET, REQ_GET_UNCHK, REQ_SEQ: begin
                off = (kind == REQ_SEQ) ? pos : 64'(off_in);
                n = (cfg_active == 0) ? 1 :
                    (cfg_active > NUM_WINDOWS) ? NUM_WINDOWS : int'(cfg_active);
                // hit search over active entries
                for (i = 0; i < n && !found; i++) begin
                    if (off >= win_start[i] && win_limit[i] > off &&
                        win_limit[i] - off > len) begin
                        found       = 1'b1;
                        win_used[i] = 1'b1;
                        r.status    = STAT_HIT;
                        r.entry     = EIDX_W'(i);
                        r.bie       = BIE_W'(off - win_start[i]);
                    end
                end
                if (found) begin
                    if (kind == REQ_SEQ) rd_pos = OFF_W'(pos + len);
                end else begin
                    // second chance: clear used bits until a clear one turns up
                    for (i = 0; i <= 2 * n; i++) begin
                        if (!win_used[v]) break;
                        win_used[v] = 1'b0;
                        v = (v + 1) % n;
                    end
                    st = off & ~64'(ALIGN_BYTES - 1);
                    if (cfg_file_size < st || cfg_file_size - st < cfg_chunk)
                        lim = cfg_file_size;
                    else
                        lim = (st + cfg_chunk) & OFF_MASK;
                    r.entry = EIDX_W'(v);
                    if (kind != REQ_GET_UNCHK && (lim < off || lim - off < len)) begin
                        r.status = STAT_BEYOND;
                    end else begin
                        win_start[v] = st;
                        win_limit[v] = lim;
                        win_used[v]  = 1'b1;
                        r.status     = STAT_MISS;
                        r.bie        = BIE_W'(off - st);
                        r.fill_start = OFF_W'(st);
                        r.fill_len   = (lim > st) ? LEN_W'(lim - st) : '0;
                        if (kind == REQ_SEQ) rd_pos = OFF_W'(pos + len);
                    end
                end
            end
            REQ_SET: begin
                if (64'(off_in) > cfg_file_size) begin
                    r.status = STAT_REJECT;
                end else begin
                    rd_pos   = off_in;
                    r.status = STAT_ACCEPT;
                end
            end
            REQ_MOVE: begin
                np = '0;
                if (delta[31]) begin
                    mag = 64'h1_0000_0000 - 64'(delta);
                    ok  = (mag <= pos);
                    if (ok) begin
                        np = pos - mag;
                        ok = (np <= cfg_file_size);
                    end
                end else begin
                    ok = (pos <= cfg_file_size) && (64'(delta) <= cfg_file_size - pos);
                    if (ok) np = pos + 64'(delta);
                end
                if (ok) begin
                    rd_pos   = OFF_W'(np);
                    r.status = STAT_ACCEPT;
                end else begin
                    r.status = STAT_REJECT;
                end
            end
            default: r.status = STAT_REJECT;
        endcase
        r.rd_pos = rd_pos;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input cache_result_t e,
                                   input cache_result_t a);
        err_count++;
        if (err_count <= 10)
            $display("%0t %s: exp st=%0d idx=%0d bie=%0h fs=%0h fl=%0h pos=%0h | got st=%0d idx=%0d bie=%0h fs=%0h fl=%0h pos=%0h",
                     $time, what, e.status, e.entry, e.bie, e.fill_start, e.fill_len,
                     e.rd_pos, a.status, a.entry, a.bie, a.fill_start, a.fill_len,
                     a.rd_pos);
    endtask

    // check result transactions first, then predict the accepted request
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got_result.status     = m_tuser;
                got_result.entry      = m_tdata[2:0];
                got_result.bie        = m_tdata[18:3];
                got_result.fill_start = m_tdata[66:19];
                got_result.fill_len   = m_tdata[83:67];
                got_result.rd_pos     = m_tdata[131:84];
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got_result);
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result.status !== want_result.status ||
                        got_result.entry !== want_result.entry ||
                        got_result.bie !== want_result.bie ||
                        got_result.fill_start !== want_result.fill_start ||
                        got_result.fill_len !== want_result.fill_len ||
                        got_result.rd_pos !== want_result.rd_pos)
                        report_mismatch("result mismatch", want_result, got_result);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(predict_access(s_tuser, s_tdata[47:0],
                                                         s_tdata[64:48], s_tdata[96:65]));
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("file_window_cache_clock verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request transaction; returns at the edge where it is accepted
    task automatic send_req(input logic [2:0] kind, input logic [47:0] off,
                            input logic [16:0] len, input logic [31:0] delta);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= kind;
        s_tdata  <= {7'b0, delta, len, off};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and let every pending result come out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            CFG_FILE_SIZE: begin
                cfg_file_size = 64'(data);
                clear_windows();
            end
            CFG_CHUNK:  cfg_chunk  = 64'(data[LEN_W-1:0]);
            CFG_CHUNKS: cfg_active = data[CHUNKS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [47:0] fsize, input logic [16:0] chunk,
                              input logic [3:0] active);
        wait_results_drained();
        write_reg(CFG_FILE_SIZE, fsize);
        write_reg(CFG_CHUNK, 48'(chunk));
        write_reg(CFG_CHUNKS, 48'(active));
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    // offsets biased toward the cached region, the file end and the read position
    function automatic logic [47:0] rand_offset();
        int          r;
        logic [63:0] d;
        r = $urandom_range(0, 99);
        if (r < 55) return 48'($urandom_range(0, int'(cfg_chunk) * 12));
        if (r < 70) begin
            d = 64'($urandom_range(0, 2 * int'(cfg_chunk)));
            return (cfg_file_size > d) ? 48'(cfg_file_size - d) : '0;
        end
        if (r < 78) return 48'(cfg_file_size + 64'($urandom_range(0, 1024)));
        if (r < 88) return 48'(64'(rd_pos) + 64'($urandom_range(0, int'(cfg_chunk))));
        return rand48();
    endfunction

    function automatic logic [16:0] rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 75) return 17'($urandom_range(1, 256));
        if (r < 92) return 17'($urandom_range(0, int'(cfg_chunk)));
        if (r < 98) return 17'($urandom_range(0, 65536));
        return 17'd65536;
    endfunction

    function automatic logic [31:0] rand_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 32'($urandom_range(0, 2048));
        if (r < 60) return -32'($urandom_range(1, 2048));
        if (r < 90) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    // reset values: empty file, default chunk and entry count
    task automatic test_reset_state();
        send_req(REQ_GET, 48'd0, 17'd0, 32'd0);
        send_req(REQ_SET, 48'd1, 17'd0, 32'd0);
        send_req(REQ_MOVE, 48'd0, 17'd0, 32'd1);
    endtask

    // hits, fills, beyond-file, unchecked fills and windows past the file end
    task automatic test_get_requests();
        set_config(48'd100000, 17'd4096, 4'd8);
        send_req(REQ_GET, 48'd700, 17'd16, 32'd0);
        send_req(REQ_GET, 48'd1000, 17'd3607, 32'd0);
        send_req(REQ_GET, 48'd1000, 17'd3608, 32'd0);
        send_req(REQ_GET_UNCHK, 48'd99000, 17'd4000, 32'd0);
        send_req(REQ_GET, 48'd99900, 17'd200, 32'd0);
        send_req(REQ_GET, 48'hFFFF_FFFF_FFFF, 17'd65536, 32'd0);
        send_req(REQ_GET_UNCHK, 48'hFFFF_FFFF_FFFF, 17'd65536, 32'd0);
    endtask

    // sequential reads advance, and stand still on beyond file
    task automatic test_sequential_reads();
        send_req(REQ_SET, 48'd4000, 17'd0, 32'd0);
        send_req(REQ_SEQ, 48'd0, 17'd100, 32'd0);
        send_req(REQ_SEQ, 48'd0, 17'd65536, 32'd0);
    endtask

    // set and move within and outside 0..file_size
    task automatic test_position_moves();
        send_req(REQ_MOVE, 48'd0, 17'd0, -32'd4000);
        send_req(REQ_MOVE, 48'd0, 17'd0, 32'h8000_0000);
        send_req(REQ_MOVE, 48'd0, 17'd0, 32'h7FFF_FFFF);
        send_req(REQ_SET, 48'd100000, 17'd0, 32'd0);
        send_req(REQ_MOVE, 48'd0, 17'd0, 32'd0);
        send_req(REQ_SET, 48'd100001, 17'd0, 32'd0);
    endtask

    // entry count of zero acts as one, above the table size as the table size
    task automatic test_active_entry_count();
        set_config(48'd100000, 17'd4096, 4'd0);
        send_req(REQ_GET, 48'd0, 17'd8, 32'd0);
        send_req(REQ_GET, 48'd5000, 17'd8, 32'd0);
        set_config(48'd100000, 17'd512, 4'd15);
        send_req(REQ_GET, 48'd0, 17'd8, 32'd0);
        send_req(REQ_GET, 48'd1024, 17'd8, 32'd0);
    endtask

    task automatic test_unused_request_types();
        send_req(3'd5, 48'd0, 17'd0, 32'd0);
        send_req(3'd7, 48'hFFFF_FFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
    endtask

    // one random phase under a given idling mix
    task automatic run_random_phase(input int items, input int send_pct, input int recv_pct,
                                    input bit hold_midway);
        int          r;
        logic [2:0]  kind;
        logic [47:0] off;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int i = 0; i < items; i++) begin
            if (hold_midway && i == items / 2) wait_results_drained();
            r = $urandom_range(0, 99);
            if (r < 32)      kind = REQ_GET;
            else if (r < 42) kind = REQ_GET_UNCHK;
            else if (r < 67) kind = REQ_SEQ;
            else if (r < 79) kind = REQ_SET;
            else if (r < 95) kind = REQ_MOVE;
            else             kind = 3'($urandom_range(5, 7));
            if (kind == REQ_SET) begin
                r = $urandom_range(0, 99);
                if (r < 70)      off = rand_offset();
                else if (r < 85) off = 48'(64'(rand48()) % (cfg_file_size + 1));
                else             off = 48'(cfg_file_size + 64'($urandom_range(0, 3)));
            end else begin
                off = rand_offset();
            end
            send_req(kind, off, rand_length(), rand_delta());
        end
    endtask

    task automatic test_random_traffic();
        set_config(48'd200000, 17'd4096, 4'd8);
        run_random_phase(170, 0, 0, 1'b0);
        set_config(48'd200000, 17'd512, 4'd8);
        run_random_phase(170, 87, 0, 1'b0);
        set_config(48'd1000000, 17'd65536, 4'd3);
        run_random_phase(170, 0, 87, 1'b1);
        set_config(48'hFFFF_FFFF_FFFF, 17'd4096, 4'd8);
        run_random_phase(170, 36, 36, 1'b0);
        set_config(48'd0, 17'd4096, 4'd1);
        run_random_phase(100, 0, 0, 1'b0);
        set_config(48'd30000, 17'd1024, 4'd8);
        run_random_phase(180, 36, 36, 1'b0);
        set_config(48'd5000, 17'd65536, 4'd4);
        run_random_phase(170, 87, 87, 1'b0);
        set_config(48'd123457, 17'd2048, 4'd15);
        run_random_phase(170, 36, 36, 1'b0);
    endtask

    initial begin
        cfg_file_size = '0;
        cfg_chunk     = 64'(CHUNK_RESET);
        cfg_active    = CHUNKS_RESET;
        clear_windows();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_get_requests();
        test_sequential_reads();
        test_position_moves();
        test_active_entry_count();
        test_unused_request_types();
        test_random_traffic();

        wait_results_drained();
        if (pending_results.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("file_window_cache_clock verification clean");
        end else begin
            $display("file_window_cache_clock verification failed");
        end
        $finish;
    end

endmodule
